// ----- rtl/core/tkbf_pkg.sv -----
package tkbf_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int KEY_W   = 32;
    localparam int ID_W    = 31;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [ID_W-1:0]  ID_LAST  = {ID_W{1'b1}};

    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_TAKE_WT  = 2'd1;
    localparam logic [1:0] OP_TAKE_VOL = 2'd2;

    typedef enum logic [1:0] {
        ST_ADDED   = 2'd0,
        ST_FOUND   = 2'd1,
        ST_NONE    = 2'd2,
        ST_REFUSED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        K_ADD,
        K_TAKE_WT,
        K_TAKE_VOL,
        K_NOP
    } kind_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SEEK,
        B_SCAN,
        B_DRAIN,
        B_FINISH
    } bstate_t;

    typedef struct packed {
        kind_t                   kind;
        logic signed [KEY_W-1:0] weight;
        logic signed [KEY_W-1:0] volume;
        logic signed [KEY_W-1:0] threshold;
    } req_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] weight;
        logic signed [KEY_W-1:0] volume;
        logic [ID_W-1:0]         serial;
    } slot_t;

endpackage

// ----- rtl/core/tkbf_front.sv -----
module tkbf_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [1:0]                          operation,
    input  logic signed [tkbf_pkg::KEY_W-1:0]   weight,
    input  logic signed [tkbf_pkg::KEY_W-1:0]   volume,
    input  logic signed [tkbf_pkg::KEY_W-1:0]   threshold,
    input  logic                                pop,
    output logic                                busy,
    output logic                                q_valid,
    output tkbf_pkg::req_t                      q_data
);

    tkbf_pkg::req_t                    fifo_reg [tkbf_pkg::QDEPTH];
    logic [tkbf_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [tkbf_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [tkbf_pkg::QCNT_W-1:0]       count_reg, count_next;
    tkbf_pkg::req_t                    req_in;
    tkbf_pkg::kind_t                   kind;
    logic                              push;
    logic                              do_pop;

    always_comb
    begin
        case (operation)
            tkbf_pkg::OP_ADD:      kind = tkbf_pkg::K_ADD;
            tkbf_pkg::OP_TAKE_WT:  kind = tkbf_pkg::K_TAKE_WT;
            tkbf_pkg::OP_TAKE_VOL: kind = tkbf_pkg::K_TAKE_VOL;
            default:               kind = tkbf_pkg::K_NOP;
        endcase
    end

    assign req_in  = '{kind: kind, weight: weight, volume: volume, threshold: threshold};
    assign busy    = (count_reg == tkbf_pkg::QCNT_W'(tkbf_pkg::QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = fifo_reg[rd_ptr_reg];
    assign push    = start && !busy;
    assign do_pop  = pop && q_valid;

    // pointers wrap through the full depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == tkbf_pkg::QPTR_W'(tkbf_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == tkbf_pkg::QPTR_W'(tkbf_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= req_in;
        end
    end

endmodule

// ----- rtl/core/tkbf_back.sv -----
module tkbf_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  tkbf_pkg::req_t                  q_data,
    output logic                            pop,
    output logic                            done,
    output logic [1:0]                      status,
    output logic [tkbf_pkg::ID_W-1:0]       entry_id
);

    tkbf_pkg::slot_t                   mem [tkbf_pkg::ENTRIES];
    tkbf_pkg::slot_t                   mem_q;
    logic                              mem_we;
    tkbf_pkg::slot_t                   mem_wdata;

    tkbf_pkg::bstate_t                 state_reg, state_next;
    tkbf_pkg::req_t                    cur_reg, cur_next;
    logic [tkbf_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic                              rd_pend_reg, rd_pend_next;
    logic [tkbf_pkg::IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic                              best_found_reg, best_found_next;
    logic signed [tkbf_pkg::KEY_W-1:0] best_key_reg, best_key_next;
    logic [tkbf_pkg::ID_W-1:0]         best_id_reg, best_id_next;
    logic [tkbf_pkg::IDX_W-1:0]        best_idx_reg, best_idx_next;
    logic [tkbf_pkg::ENTRIES-1:0]      valid_reg, valid_next;
    logic [tkbf_pkg::ID_W-1:0]         ctr_reg, ctr_next;
    logic                              done_reg, done_next;
    tkbf_pkg::status_t                 status_reg, status_next;
    logic [tkbf_pkg::ID_W-1:0]         id_reg, id_next;

    logic signed [tkbf_pkg::KEY_W-1:0] key;
    logic                              qualifies;
    logic                              better;

    assign done     = done_reg;
    assign status   = status_reg;
    assign entry_id = id_reg;

    // compare stage for the slot read in the previous cycle
    assign key       = (cur_reg.kind == tkbf_pkg::K_TAKE_VOL) ? $signed(mem_q.volume)
                                                             : $signed(mem_q.weight);
    assign qualifies = rd_pend_reg && valid_reg[rd_idx_reg]
                       && (key >= $signed(cur_reg.threshold));
    assign better    = !best_found_reg || (key < best_key_reg)
                       || ((key == best_key_reg) && (mem_q.serial < best_id_reg));

    assign mem_wdata = '{weight: cur_reg.weight, volume: cur_reg.volume, serial: ctr_reg};

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        idx_next        = idx_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        best_found_next = best_found_reg;
        best_key_next   = best_key_reg;
        best_id_next    = best_id_reg;
        best_idx_next   = best_idx_reg;
        valid_next      = valid_reg;
        ctr_next        = ctr_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        id_next         = id_reg;
        pop             = 1'b0;
        mem_we          = 1'b0;

        if (qualifies && better)
        begin
            best_found_next = 1'b1;
            best_key_next   = key;
            best_id_next    = mem_q.serial;
            best_idx_next   = rd_idx_reg;
        end

        case (state_reg)
            tkbf_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    pop             = 1'b1;
                    cur_next        = q_data;
                    idx_next        = '0;
                    best_found_next = 1'b0;
                    case (q_data.kind)
                        tkbf_pkg::K_ADD:
                        begin
                            if (ctr_reg == tkbf_pkg::ID_LAST)
                            begin
                                done_next   = 1'b1;
                                status_next = tkbf_pkg::ST_REFUSED;
                                id_next     = '0;
                            end
                            else
                            begin
                                state_next = tkbf_pkg::B_SEEK;
                            end
                        end
                        tkbf_pkg::K_TAKE_WT, tkbf_pkg::K_TAKE_VOL:
                        begin
                            state_next = tkbf_pkg::B_SCAN;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = tkbf_pkg::ST_NONE;
                            id_next     = '0;
                        end
                    endcase
                end
            end
            // walk the valid bits for the lowest free slot
            tkbf_pkg::B_SEEK:
            begin
                if (!valid_reg[idx_reg])
                begin
                    mem_we              = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    ctr_next            = ctr_reg + 1'b1;
                    done_next           = 1'b1;
                    status_next         = tkbf_pkg::ST_ADDED;
                    id_next             = ctr_reg;
                    state_next          = tkbf_pkg::B_IDLE;
                end
                else if (idx_reg == tkbf_pkg::LAST_IDX)
                begin
                    done_next   = 1'b1;
                    status_next = tkbf_pkg::ST_REFUSED;
                    id_next     = '0;
                    state_next  = tkbf_pkg::B_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            tkbf_pkg::B_SCAN:
            begin
                rd_pend_next = 1'b1;
                rd_idx_next  = idx_reg;
                if (idx_reg == tkbf_pkg::LAST_IDX)
                begin
                    state_next = tkbf_pkg::B_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            tkbf_pkg::B_DRAIN:
            begin
                state_next = tkbf_pkg::B_FINISH;
            end
            tkbf_pkg::B_FINISH:
            begin
                done_next  = 1'b1;
                state_next = tkbf_pkg::B_IDLE;
                if (best_found_reg)
                begin
                    valid_next[best_idx_reg] = 1'b0;
                    status_next              = tkbf_pkg::ST_FOUND;
                    id_next                  = best_id_reg;
                end
                else
                begin
                    status_next = tkbf_pkg::ST_NONE;
                    id_next     = '0;
                end
            end
            default:
            begin
                state_next = tkbf_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tkbf_pkg::B_IDLE;
            rd_pend_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            valid_reg      <= '0;
            ctr_reg        <= '0;
            done_reg       <= 1'b0;
            status_reg     <= tkbf_pkg::ST_NONE;
            id_reg         <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_pend_reg    <= rd_pend_next;
            best_found_reg <= best_found_next;
            valid_reg      <= valid_next;
            ctr_reg        <= ctr_next;
            done_reg       <= done_next;
            status_reg     <= status_next;
            id_reg         <= id_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        idx_reg      <= idx_next;
        rd_idx_reg   <= rd_idx_next;
        best_key_reg <= best_key_next;
        best_id_reg  <= best_id_next;
        best_idx_reg <= best_idx_next;
    end

    // slot store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= mem_wdata;
        end
        mem_q <= mem[idx_reg];
    end

endmodule

// ----- rtl/core/two_key_best_fit_table.sv -----
// Two-key best-fit table.
// Requests: drive operation, weight, volume and threshold with start high; the
// request is taken at a rising edge where start is high and busy is low. busy
// rises only when the two-entry request queue is full.
// operation: add (stores weight/volume, returns a new id), take by weight or
// take by volume (removes the qualifying entry with the smallest key, lowest
// id on ties). Any other code gives status "none" with id 0.
// Results: done is high for exactly one cycle with status and entry_id; there
// is no back-pressure, so the result must be captured in that cycle.
// Timing: an add walks the valid bits from slot 0 to the first free one. A
// take reads every slot through the single read port of the slot memory, one
// per cycle, plus issue, drain and removal, and it holds the back end until
// its removal is done. An unused code or an add with the ids used up is
// answered from the idle state, with no walk or scan. Requests are carried out
// one at a time; up to two more wait in the queue.
// Reset: all valid bits and the id counter clear at once and the queue empties;
// no clearing pass is needed and requests are taken right after reset.
module two_key_best_fit_table (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          operation,
    input  logic signed [tkbf_pkg::KEY_W-1:0]   weight,
    input  logic signed [tkbf_pkg::KEY_W-1:0]   volume,
    input  logic signed [tkbf_pkg::KEY_W-1:0]   threshold,
    output logic                                done,
    output logic [1:0]                          status,
    output logic [tkbf_pkg::ID_W-1:0]           entry_id
);

    logic           q_valid;
    logic           pop;
    tkbf_pkg::req_t q_data;

    tkbf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .weight    (weight),
        .volume    (volume),
        .threshold (threshold),
        .pop       (pop),
        .busy      (busy),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    tkbf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .pop      (pop),
        .done     (done),
        .status   (status),
        .entry_id (entry_id)
    );

endmodule
